// ===== src/gbd_pkg.sv =====
// Shared types, constants and angle table for the grid bearing and distance block.
package gbd_pkg;

	localparam int CORDIC_STAGES_DEF = 32;
	localparam int GUARD_BITS = 30;
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_LAT = SQRT_STEPS + 3;
	localparam int ANGLE_TAIL = 4;

	localparam logic [19:0] UNITS_INT = 20'd636619;
	localparam logic [19:0] UNITS_FRAC = 20'd809886;
	localparam logic [21:0] QUARTER = 22'd1000000;
	localparam logic [21:0] HALF = 22'd2000000;
	localparam logic [21:0] THREE_Q = 22'd3000000;
	localparam logic [22:0] FULL = 23'd4000000;

	typedef enum logic [3:0] {
		CLS_ZERO,
		CLS_NORTH,
		CLS_SOUTH,
		CLS_EAST,
		CLS_WEST,
		CLS_Q1,
		CLS_Q2,
		CLS_Q3,
		CLS_Q4
	} cls_t;

	typedef struct packed {
		logic [30:0] ax;
		logic [30:0] ay;
		cls_t cls;
	} item_t;

	// shift and subtract quotient, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in Q62, alternating series
	function automatic logic [63:0] atan_pow2(input int i);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] k;
		logic [63:0] t;
		logic neg;
		p = 64'd1 << (62 - i);
		sum = '0;
		k = 64'd1;
		neg = 1'b0;
		for (int m = 0; m < 64; m++) begin
			if (p != 0) begin
				t = udiv64(p, k);
				sum = neg ? sum - t : sum + t;
				neg = !neg;
				k = k + 64'd2;
				p = p >> (2 * i);
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_5();
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] k;
		logic [63:0] t;
		logic neg;
		p = udiv64(64'd1 << 62, 64'd5);
		sum = '0;
		k = 64'd1;
		neg = 1'b0;
		for (int m = 0; m < 40; m++) begin
			if (p != 0) begin
				t = udiv64(p, k);
				sum = neg ? sum - t : sum + t;
				neg = !neg;
				k = k + 64'd2;
				p = udiv64(p, 64'd25);
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_239();
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] k;
		logic [63:0] t;
		logic neg;
		p = udiv64(64'd1 << 62, 64'd239);
		sum = '0;
		k = 64'd1;
		neg = 1'b0;
		for (int m = 0; m < 40; m++) begin
			if (p != 0) begin
				t = udiv64(p, k);
				sum = neg ? sum - t : sum + t;
				neg = !neg;
				k = k + 64'd2;
				p = udiv64(p, 64'd57121);
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_q62(input int i);
		logic [63:0] r;
		if (i == 0)
			r = (atan_5() << 2) - atan_239();
		else if (i <= 20)
			r = atan_pow2(i);
		else if (i < 62)
			r = 64'd1 << (62 - i);
		else
			r = '0;
		return r;
	endfunction

endpackage

// ===== src/gbd_front.sv =====
// Front stage: takes a coordinate pair, forms magnitudes and classifies the direction.
module gbd_front import gbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [30:0] delta_east,
	input  logic [30:0] delta_north,
	output logic        push,
	output item_t       push_item,
	input  logic        q_full
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;

	always_comb begin
		item_c.ax = delta_north[30] ? (~delta_north + 31'd1) : delta_north;
		item_c.ay = delta_east[30] ? (~delta_east + 31'd1) : delta_east;
		if (delta_north == '0 && delta_east == '0)
			item_c.cls = CLS_ZERO;
		else if (delta_north == '0)
			item_c.cls = delta_east[30] ? CLS_WEST : CLS_EAST;
		else if (delta_east == '0)
			item_c.cls = delta_north[30] ? CLS_SOUTH : CLS_NORTH;
		else if (!delta_north[30] && !delta_east[30])
			item_c.cls = CLS_Q1;
		else if (delta_north[30] && !delta_east[30])
			item_c.cls = CLS_Q2;
		else if (delta_north[30])
			item_c.cls = CLS_Q3;
		else
			item_c.cls = CLS_Q4;
	end

	assign in_stall = valid_s1 && q_full;
	assign push = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= item_c;
	end

endmodule

// ===== src/gbd_fifo.sv =====
// Two-entry queue between the front and back parts.
module gbd_fifo import gbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);

	item_t      mem_q [0:1];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

// ===== src/gbd_back.sv =====
// Back part: pipelined CORDIC bearing lane and pipelined square root distance lane.
module gbd_back import gbd_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  item_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [21:0] bearing,
	output logic [30:0] distance
);

	localparam int CS = CORDIC_STAGES;
	localparam int LAT_A = CS + ANGLE_TAIL;
	localparam int DEPTH = (LAT_A > SQRT_LAT) ? LAT_A : SQRT_LAT;
	localparam int PADA = DEPTH - LAT_A;
	localparam int PADS = DEPTH - SQRT_LAT;

	logic en;
	logic [DEPTH:1] v_q;

	assign en = !(v_q[DEPTH] && out_stall);
	assign pop = en && head_valid;
	assign out_valid = v_q[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[DEPTH-1:1], head_valid};
	end

	// bearing lane
	logic signed [63:0] cx_q [1:CS];
	logic signed [63:0] cy_q [1:CS];
	logic signed [63:0] cz_q [1:CS];
	cls_t               cls_q [1:CS+3];

	for (genvar k = 1; k <= CS; k++) begin : g_cordic
		localparam logic signed [63:0] ATN = atan_q62(k - 1);
		logic signed [63:0] xi, yi, zi;
		cls_t ci;
		if (k == 1) begin : g_first
			assign xi = {3'b000, head.ax, 30'd0};
			assign yi = {3'b000, head.ay, 30'd0};
			assign zi = '0;
			assign ci = head.cls;
		end else begin : g_next
			assign xi = cx_q[k-1];
			assign yi = cy_q[k-1];
			assign zi = cz_q[k-1];
			assign ci = cls_q[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[63]) begin
					cx_q[k] <= xi + (yi >>> (k - 1));
					cy_q[k] <= yi - (xi >>> (k - 1));
					cz_q[k] <= zi + ATN;
				end else begin
					cx_q[k] <= xi - (yi >>> (k - 1));
					cy_q[k] <= yi + (xi >>> (k - 1));
					cz_q[k] <= zi - ATN;
				end
				cls_q[k] <= ci;
			end
		end
	end

	logic [63:0] zr;
	logic [40:0] th_q;
	logic [60:0] p1_q;
	logic [40:0] p2_q;
	logic [60:0] pf;
	logic [61:0] usum;
	logic [21:0] u;
	logic [19:0] q_q;
	logic [21:0] brg_q [0:PADA];
	logic [21:0] brg_c;

	always_comb begin
		zr = (cz_q[CS][63] ? 64'd0 : cz_q[CS]) + (64'd1 << 21);
		pf = th_q * UNITS_FRAC;
		usum = {1'b0, p1_q} + {21'd0, p2_q} + (62'd1 << 39);
		u = usum[61:40];
	end

	always_comb begin
		case (cls_q[CS+3])
			CLS_ZERO, CLS_NORTH: brg_c = '0;
			CLS_SOUTH:           brg_c = HALF;
			CLS_EAST:            brg_c = QUARTER;
			CLS_WEST:            brg_c = THREE_Q;
			CLS_Q1:              brg_c = {2'b00, q_q};
			CLS_Q2:              brg_c = HALF - {2'b00, q_q};
			CLS_Q3:              brg_c = HALF + {2'b00, q_q};
			CLS_Q4:              brg_c = (q_q == '0) ? 22'd0 : FULL[21:0] - {2'b00, q_q};
			default:             brg_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_q <= zr[62:22];
			cls_q[CS+1] <= cls_q[CS];
			p1_q <= th_q * UNITS_INT;
			p2_q <= pf[60:20];
			cls_q[CS+2] <= cls_q[CS+1];
			q_q <= (u > QUARTER) ? QUARTER[19:0] : u[19:0];
			cls_q[CS+3] <= cls_q[CS+2];
			brg_q[0] <= brg_c;
		end
	end

	for (genvar k = 1; k <= PADA; k++) begin : g_pada
		always_ff @(posedge clk) begin
			if (en)
				brg_q[k] <= brg_q[k-1];
		end
	end

	// distance lane
	logic [61:0] sa_q, sb_q;
	logic [63:0] n_q [0:SQRT_STEPS];
	logic [63:0] r_q [0:SQRT_STEPS];
	logic [30:0] dst_q [0:PADS];

	always_ff @(posedge clk) begin
		if (en) begin
			sa_q <= head.ax * head.ax;
			sb_q <= head.ay * head.ay;
			n_q[0] <= {2'b00, sa_q} + {2'b00, sb_q};
			r_q[0] <= '0;
			dst_q[0] <= (n_q[SQRT_STEPS] > r_q[SQRT_STEPS]) ?
				r_q[SQRT_STEPS][30:0] + 31'd1 : r_q[SQRT_STEPS][30:0];
		end
	end

	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (64 - 2 * k);
		logic [63:0] trial;
		assign trial = r_q[k-1] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_q[k-1] >= trial) begin
					n_q[k] <= n_q[k-1] - trial;
					r_q[k] <= (r_q[k-1] >> 1) + BIT;
				end else begin
					n_q[k] <= n_q[k-1];
					r_q[k] <= r_q[k-1] >> 1;
				end
			end
		end
	end

	for (genvar k = 1; k <= PADS; k++) begin : g_pads
		always_ff @(posedge clk) begin
			if (en)
				dst_q[k] <= dst_q[k-1];
		end
	end

	assign bearing = brg_q[PADA];
	assign distance = dst_q[PADS];

endmodule

// ===== src/grid_bearing_and_distance.sv =====
// Top level: grid bearing (0.0001 gon) and horizontal distance from coordinate differences.
// Path: a front register, the two-entry queue, then the back pipeline, whose depth is the
// longer of the CORDIC bearing lane and the square root distance lane.
// Throughput: one transaction per cycle without out_stall; both lanes are fully pipelined.
// The back pipeline freezes as a whole while a finished result is stalled at the output.
// Reset: arst_n clears the valid bits and queue pointers; data registers are not reset.
module grid_bearing_and_distance import gbd_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [30:0] delta_east,
	input  logic [30:0] delta_north,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [21:0] bearing,
	output logic [30:0] distance
);

	logic  push, q_full, pop, head_valid;
	item_t push_item, head;

	gbd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.delta_east(delta_east), .delta_north(delta_north),
		.push(push), .push_item(push_item), .q_full(q_full)
	);

	gbd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(q_full),
		.pop(pop), .head_valid(head_valid), .head(head)
	);

	gbd_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head_valid(head_valid), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.bearing(bearing), .distance(distance)
	);

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, bearing} < FULL))
		else $error("bearing out of range");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && distance == '0) |-> (bearing == '0))
		else $error("zero distance with nonzero bearing");

	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue overflow");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for grid_bearing_and_distance: random and directed pairs against a predictor.
`timescale 1ns / 1ps

module tb_top import gbd_pkg::*; ();

	localparam int STAGES = 32;
	localparam int N_RANDOM = 1430;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [30:0] delta_east;
	logic [30:0] delta_north;
	logic out_valid;
	logic out_stall;
	logic [21:0] bearing;
	logic [30:0] distance;
	int mismatches;

	grid_bearing_and_distance uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.delta_east(delta_east), .delta_north(delta_north),
		.out_valid(out_valid), .out_stall(out_stall),
		.bearing(bearing), .distance(distance)
	);

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// arctangent of 1/n in Q62 by alternating series
	function automatic logic [63:0] arctan_inv(input logic [63:0] n);
		logic [63:0] p, n2, acc, k;
		bit neg;
		p = (64'd1 << 62) / n;
		n2 = n * n;
		acc = 0;
		k = 1;
		neg = 0;
		while (p != 0) begin
			acc = neg ? acc - p / k : acc + p / k;
			neg = !neg;
			k += 2;
			p = p / n2;
		end
		return acc;
	endfunction

	function automatic longint angle_step(input int i);
		if (i == 0) return longint'(4 * arctan_inv(5) - arctan_inv(239));
		if (i <= 20) return longint'(arctan_inv(64'd1 << i));
		if (i < 62) return longint'(64'd1 << (62 - i));
		return 0;
	endfunction

	function automatic longint floor_shift(input longint v, input int s);
		if (s > 62) return v < 0 ? -1 : 0;
		return v >>> s;
	endfunction

	function automatic logic [63:0] quadrant_angle(input longint a, input longint b);
		longint x, y, z, xs, ys;
		logic [63:0] th, u;
		x = a <<< GUARD_BITS;
		y = b <<< GUARD_BITS;
		z = 0;
		for (int i = 0; i < STAGES; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += angle_step(i);
			end else begin
				x -= ys; y += xs; z -= angle_step(i);
			end
		end
		if (z < 0) z = 0;
		th = (64'(z) + (64'd1 << 21)) >> 22;
		u = th * 64'd636619 + ((th * 64'd809886) >> 20);
		u = (u + (64'd1 << 39)) >> 40;
		if (u > 64'd1000000) u = 64'd1000000;
		return u;
	endfunction

	function automatic logic [63:0] rounded_root(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		if (n > r) r++;
		return r;
	endfunction

	typedef struct {
		logic [21:0] brg;
		logic [30:0] span;
	} survey_t;

	class survey_board;
		survey_t pending[$];

		function void note_pair(logic [30:0] de, logic [30:0] dn);
			longint dy, dx, ax, ay;
			logic [63:0] q, b;
			survey_t s;
			dy = longint'(signed'(de));
			dx = longint'(signed'(dn));
			ay = dy < 0 ? -dy : dy;
			ax = dx < 0 ? -dx : dx;
			if (dy == 0 && dx == 0) b = 0;
			else if (dx == 0) b = dy > 0 ? 1000000 : 3000000;
			else if (dy == 0) b = dx > 0 ? 0 : 2000000;
			else begin
				q = quadrant_angle(ax, ay);
				if (dx > 0 && dy > 0) b = q;
				else if (dx < 0 && dy > 0) b = 2000000 - q;
				else if (dx < 0) b = 2000000 + q;
				else b = 4000000 - q;
				if (b >= 4000000) b = 0;
			end
			s.brg = b[21:0];
			s.span = 31'(rounded_root(ax * ax + ay * ay));
			pending.push_back(s);
		endfunction

		task check_result(logic [21:0] brg, logic [30:0] span);
			survey_t s;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %0d %0d", brg, span));
				return;
			end
			s = pending.pop_front();
			if (brg !== s.brg)
				report($sformatf("bearing %0d expected %0d", brg, s.brg));
			if (span !== s.span)
				report($sformatf("distance %0d expected %0d", span, s.span));
		endtask
	endclass

	survey_board board;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("grid_bearing_and_distance verification failed");
		$finish;
	end

	task automatic send_pair(input longint de, input longint dn);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		repeat (gap) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		delta_east <= 31'(de);
		delta_north <= 31'(dn);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_pair(31'(de), 31'(dn));
		@(negedge clk);
	endtask

	function automatic logic [30:0] rand_coord();
		int m;
		m = $urandom_range(0, 9);
		if (m == 0) return 31'($urandom);
		if (m == 1) return 31'($urandom_range(0, 4)) - 31'd2;
		if (m == 2) return 31'(signed'($urandom_range(0, 2000)) - 1000);
		if (m == 3) return 31'($urandom_range(0, 1) ? 1000000000 : -1000000000);
		return 31'(longint'($urandom_range(0, 2000000000)) - 1000000000);
	endfunction

	// receiver stall
	initial begin
		int w;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (w != 0) begin
				out_stall <= 1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) board.check_result(bearing, distance);

	initial begin
		int waited;
		board = new();
		mismatches = 0;
		arst_n = 0;
		in_valid = 0;
		delta_east = 0;
		delta_north = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_pair(0, 0);
		send_pair(5, 0);
		send_pair(-5, 0);
		send_pair(0, 7);
		send_pair(0, -7);
		send_pair(3, 3);
		send_pair(3, -3);
		send_pair(-3, 3);
		send_pair(-3, -3);
		send_pair(1, 1000000000);
		send_pair(-1, 1000000000);
		send_pair(1000000000, 1);
		send_pair(-1000000000, -1000000000);
		send_pair(1000000000, -1);
		send_pair(31'h3FFFFFFF, 31'h40000000);
		send_pair(31'h40000000, 31'h40000000);
		send_pair(31'h7FFFFFFF, 31'h7FFFFFFF);
		send_pair(-1, 31'h40000000);
		send_pair(-1, -1000000000);
		for (int i = 0; i < N_RANDOM; i++)
			send_pair(rand_coord(), rand_coord());
		in_valid <= 0;
		waited = 0;
		while (board.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (board.pending.size() != 0)
			report($sformatf("%0d results never arrived", board.pending.size()));
		if (mismatches == 0)
			$display("grid_bearing_and_distance verification clean");
		else
			$display("grid_bearing_and_distance verification failed");
		$finish;
	end
endmodule
